// File: design/nps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_pkg
// Widths, codes, the grid scaling table and the controller/datapath bundles
// of the nearest palette color search.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
  localparam int GRID_LEVELS     = 32;
  localparam int GRID_W          = $clog2(GRID_LEVELS);
  localparam int CHAN_W          = 8;
  localparam int PAL_W           = 3 * CHAN_W;
  localparam int SQ_W            = 2 * CHAN_W;
  // three squares summed: two more bits than one square
  localparam int DIST_W          = SQ_W + 2;

  // last searched entry: the top entry of the palette is left out
  localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(PALETTE_ENTRIES - 2);

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // level * 255 / 31, truncated
  localparam logic [CHAN_W-1:0] SCALE_TABLE [GRID_LEVELS] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  typedef struct packed {
    logic write_entry;
    logic start_query;
    logic step;
    logic finish;
  } nps_cmd_t;

  typedef struct packed {
    logic last_addr;
    logic pipe_empty;
    logic out_free;
  } nps_status_t;

endpackage

// File: design/nps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_if
// Request and response channels of the nearest palette color search.
// ----------------------------------------------------------------------------
interface nps_req_if import nps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [IDX_W-1:0]  entry_index;
  logic [CHAN_W-1:0] entry_red;
  logic [CHAN_W-1:0] entry_green;
  logic [CHAN_W-1:0] entry_blue;
  logic [GRID_W-1:0] grid_red;
  logic [GRID_W-1:0] grid_green;
  logic [GRID_W-1:0] grid_blue;

  modport source (
    output valid, action, entry_index, entry_red, entry_green, entry_blue,
           grid_red, grid_green, grid_blue,
    input  ready
  );
  modport sink (
    input  valid, action, entry_index, entry_red, entry_green, entry_blue,
           grid_red, grid_green, grid_blue,
    output ready
  );
endinterface

interface nps_rsp_if import nps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] nearest_index;

  modport source (output valid, nearest_index, input ready);
  modport sink (input valid, nearest_index, output ready);
endinterface

// File: design/nps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_ctrl
// Sequencer: takes words, walks the palette for a query, drains the compare
// pipeline and hands the winner to the output register.
// ----------------------------------------------------------------------------
module nps_ctrl import nps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_action,
  output logic        in_ready,
  input  nps_status_t status,
  output nps_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.write_entry = in_ready && in_valid && (in_action == ACT_LOAD);
    cmd.start_query = in_ready && in_valid && (in_action == ACT_QUERY);
    cmd.step        = (state == ST_SEARCH);
    cmd.finish      = (state == ST_FINISH) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.start_query) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (status.last_addr) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (status.pipe_empty) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (status.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/nps_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_datapath
// Palette memory, target scaling, three-stage distance/compare pipeline and
// the result register.
// ----------------------------------------------------------------------------
module nps_datapath import nps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  nps_cmd_t          cmd,
  output nps_status_t       status,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic [CHAN_W-1:0] entry_red,
  input  logic [CHAN_W-1:0] entry_green,
  input  logic [CHAN_W-1:0] entry_blue,
  input  logic [GRID_W-1:0] grid_red,
  input  logic [GRID_W-1:0] grid_green,
  input  logic [GRID_W-1:0] grid_blue,
  nps_rsp_if.source         rsp
);

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  logic [PAL_W-1:0]  palette [PALETTE_ENTRIES];
  logic [IDX_W-1:0]  addr;
  logic [CHAN_W-1:0] tgt_red, tgt_green, tgt_blue;

  logic              rd_valid;
  logic [IDX_W-1:0]  rd_idx;
  logic [PAL_W-1:0]  rd_data;

  logic              sq_valid;
  logic [IDX_W-1:0]  sq_idx;
  logic [SQ_W-1:0]   sq_red, sq_green, sq_blue;

  logic [DIST_W-1:0] cand_dist;
  logic [DIST_W-1:0] best_dist;
  logic [IDX_W-1:0]  best_idx;

  logic              out_valid;
  logic [IDX_W-1:0]  out_index;

  logic [CHAN_W-1:0] diff_red, diff_green, diff_blue;

  // palette word: red low byte, blue high byte
  always_ff @(posedge clk) begin
    if (cmd.write_entry) begin
      palette[entry_index] <= {entry_blue, entry_green, entry_red};
    end
    if (cmd.step) begin
      rd_data <= palette[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else if (cmd.start_query) begin
      addr <= '0;
    end else if (cmd.step) begin
      addr <= addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      tgt_red   <= SCALE_TABLE[grid_red];
      tgt_green <= SCALE_TABLE[grid_green];
      tgt_blue  <= SCALE_TABLE[grid_blue];
    end
  end

  always_comb begin
    diff_red   = abs_diff(tgt_red,   rd_data[CHAN_W-1:0]);
    diff_green = abs_diff(tgt_green, rd_data[2*CHAN_W-1:CHAN_W]);
    diff_blue  = abs_diff(tgt_blue,  rd_data[3*CHAN_W-1:2*CHAN_W]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      sq_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.step;
      sq_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx   <= addr;
    sq_idx   <= rd_idx;
    sq_red   <= SQ_W'(diff_red) * SQ_W'(diff_red);
    sq_green <= SQ_W'(diff_green) * SQ_W'(diff_green);
    sq_blue  <= SQ_W'(diff_blue) * SQ_W'(diff_blue);
  end

  assign cand_dist = DIST_W'(sq_red) + DIST_W'(sq_green) + DIST_W'(sq_blue);

  // strict compare in ascending index order keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      best_dist <= '1;
      best_idx  <= '0;
    end else if (sq_valid && (cand_dist < best_dist)) begin
      best_dist <= cand_dist;
      best_idx  <= sq_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_index <= best_idx;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.nearest_index = out_index;

  always_comb begin
    status            = '0;
    status.last_addr  = (addr == LAST_ENTRY);
    status.pipe_empty = !rd_valid && !sq_valid;
    status.out_free   = !out_valid || rsp.ready;
  end

endmodule

// File: design/nearest_palette_color_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Palette store with a nearest-color lookup for points of a 32-level grid.
// ----------------------------------------------------------------------------
// usage:
//   req carries one word per handshake. action = load writes entry_index
//   with the given red/green/blue; action = query scales the grid point to
//   0..255 and searches palette entries 0 through 254 for the smallest
//   squared distance, lowest index on a tie.
//   rsp carries nearest_index, one word per query; loads give no word.
// sequence:
//   a load writes its palette entry when it is accepted. a query walks
//   the palette from acceptance with one palette read per cycle from the
//   single memory read port, then drains the read/square/compare pipeline
//   and loads the result register. req is taken again only after that, so
//   a new query is not accepted before the last one reaches the register.
// reset:
//   rst clears the sequencer and the result valid flag; palette contents are
//   undefined until written, so every searched entry must be loaded first.
// stalls:
//   the result register holds its word while rsp.ready is low; loads and a
//   new query are still taken, and a finished query waits for the register.
// ----------------------------------------------------------------------------
module nearest_palette_color_search import nps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  nps_req_if.sink   req,
  nps_rsp_if.source rsp
);

  nps_cmd_t    cmd;
  nps_status_t status;
  logic        in_ready;

  assign req.ready = in_ready;

  nps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_action (req.action),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  nps_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .entry_index (req.entry_index),
    .entry_red   (req.entry_red),
    .entry_green (req.entry_green),
    .entry_blue  (req.entry_blue),
    .grid_red    (req.grid_red),
    .grid_green  (req.grid_green),
    .grid_blue   (req.grid_blue),
    .rsp         (rsp)
  );

endmodule

// File: test/nearest_palette_color_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_search_tb
// Self-checking bench for the palette search. The whole palette is loaded
// first. A directed part then covers the grid corners, ties and the skipped
// top entry. After that comes a random mix of loads and queries. A scoreboard
// keeps its own copy of the palette, works out the nearest index for every
// accepted query, and compares each returned word in order. Both channels
// idle in random bursts, and the response side holds off once for a long
// time so that the request side backs up.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_tb;
  import nps_pkg::*;

  localparam int CHANNEL_TOP  = 255;
  localparam int RANDOM_WORDS = 130;
  localparam int CALM_WORDS   = 20;
  localparam int LONG_HOLD    = 1500;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    logic              action;
    logic [IDX_W-1:0]  entry_index;
    logic [CHAN_W-1:0] entry_red;
    logic [CHAN_W-1:0] entry_green;
    logic [CHAN_W-1:0] entry_blue;
    logic [GRID_W-1:0] grid_red;
    logic [GRID_W-1:0] grid_green;
    logic [GRID_W-1:0] grid_blue;
  } req_word_t;

  class palette_search_scoreboard;
    logic [PAL_W-1:0] palette [PALETTE_ENTRIES];
    logic [IDX_W-1:0] expected_index_q [$];
    int errors;
    int results_seen;

    function new();
      foreach (palette[i]) palette[i] = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    function int scaled(input int level);
      return (level * CHANNEL_TOP) / (GRID_LEVELS - 1);
    endfunction

    function int sq_diff(input int a, input int b);
      return (a - b) * (a - b);
    endfunction

    function logic [IDX_W-1:0] nearest_entry(input logic [GRID_W-1:0] lr, lg, lb);
      int tr, tg, tb, best, best_sum, d_sum;
      tr = scaled(int'(lr));
      tg = scaled(int'(lg));
      tb = scaled(int'(lb));
      best = 0;
      best_sum = 32'h7fffffff;
      // top entry is never searched
      for (int i = 0; i < PALETTE_ENTRIES - 1; i++) begin
        d_sum = sq_diff(tr, int'(palette[i][7:0]))
              + sq_diff(tg, int'(palette[i][15:8]))
              + sq_diff(tb, int'(palette[i][23:16]));
        if (d_sum < best_sum) begin
          best_sum = d_sum;
          best = i;
        end
      end
      return IDX_W'(best);
    endfunction

    function int pending();
      return expected_index_q.size();
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task note_word(input req_word_t w);
      if (w.action == ACT_LOAD) begin
        palette[w.entry_index] = {w.entry_blue, w.entry_green, w.entry_red};
      end else begin
        expected_index_q.push_back(nearest_entry(w.grid_red, w.grid_green, w.grid_blue));
      end
    endtask

    task check_result(input logic [IDX_W-1:0] got);
      logic [IDX_W-1:0] want;
      results_seen++;
      if (expected_index_q.size() == 0) begin
        report($sformatf("nearest_index %0d with no query pending", got));
      end else begin
        want = expected_index_q.pop_front();
        if (got !== want)
          report($sformatf("nearest_index got %0d, want %0d", got, want));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  bit   quiet;
  bit   hold_done;
  int   cycle_count;
  int   stall_left;
  palette_search_scoreboard sb;

  nps_req_if req ();
  nps_rsp_if rsp ();

  nearest_palette_color_search u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) sb.check_result(rsp.nearest_index);
  end

  // response side: short random stalls plus one long hold-off
  initial begin
    rsp.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp.ready = 1'b0;
        stall_left--;
      end else if (!quiet && !hold_done && sb.results_seen >= 20) begin
        hold_done = 1'b1;
        stall_left = LONG_HOLD - 1;
        rsp.ready = 1'b0;
      end else if (!quiet && $urandom_range(5) == 0) begin
        stall_left = $urandom_range(7);
        rsp.ready = 1'b0;
      end else begin
        rsp.ready = 1'b1;
      end
    end
  end

  task automatic send_word(input req_word_t w);
    @(negedge clk);
    req.action      = w.action;
    req.entry_index = w.entry_index;
    req.entry_red   = w.entry_red;
    req.entry_green = w.entry_green;
    req.entry_blue  = w.entry_blue;
    req.grid_red    = w.grid_red;
    req.grid_green  = w.grid_green;
    req.grid_blue   = w.grid_blue;
    req.valid       = 1'b1;
    do @(posedge clk); while (!req.ready);
    sb.note_word(w);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      req.valid = 1'b0;
    end
  endtask

  // fields that the action ignores carry random values
  function automatic req_word_t noise_word();
    req_word_t w;
    w.action      = ACT_LOAD;
    w.entry_index = IDX_W'($urandom);
    w.entry_red   = CHAN_W'($urandom);
    w.entry_green = CHAN_W'($urandom);
    w.entry_blue  = CHAN_W'($urandom);
    w.grid_red    = GRID_W'($urandom);
    w.grid_green  = GRID_W'($urandom);
    w.grid_blue   = GRID_W'($urandom);
    return w;
  endfunction

  task automatic load_entry(input int idx, input logic [PAL_W-1:0] color);
    req_word_t w;
    w = noise_word();
    w.action = ACT_LOAD;
    w.entry_index = IDX_W'(idx);
    {w.entry_blue, w.entry_green, w.entry_red} = color;
    send_word(w);
  endtask

  task automatic query_point(input int lr, input int lg, input int lb);
    req_word_t w;
    w = noise_word();
    w.action = ACT_QUERY;
    w.grid_red = GRID_W'(lr);
    w.grid_green = GRID_W'(lg);
    w.grid_blue = GRID_W'(lb);
    send_word(w);
  endtask

  // mix of plain random, on-grid, duplicated and corner colors to force ties
  function automatic logic [PAL_W-1:0] random_color();
    logic [PAL_W-1:0] c;
    case ($urandom_range(3))
      0: c = PAL_W'($urandom);
      1: c = {CHAN_W'(sb.scaled($urandom_range(GRID_LEVELS - 1))),
              CHAN_W'(sb.scaled($urandom_range(GRID_LEVELS - 1))),
              CHAN_W'(sb.scaled($urandom_range(GRID_LEVELS - 1)))};
      2: c = sb.palette[$urandom_range(PALETTE_ENTRIES - 2)];
      default: c = {{CHAN_W{$urandom_range(1) == 1}}, {CHAN_W{$urandom_range(1) == 1}},
                    {CHAN_W{$urandom_range(1) == 1}}};
    endcase
    return c;
  endfunction

  function automatic int random_level();
    if ($urandom_range(4) == 0) return $urandom_range(1) * (GRID_LEVELS - 1);
    return $urandom_range(GRID_LEVELS - 1);
  endfunction

  initial begin
    sb = new();
    quiet = 1'b0;
    hold_done = 1'b0;
    cycle_count = 0;
    req.valid = 1'b0;
    req.action = ACT_LOAD;
    req.entry_index = '0;
    req.entry_red = '0;
    req.entry_green = '0;
    req.entry_blue = '0;
    req.grid_red = '0;
    req.grid_green = '0;
    req.grid_blue = '0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // every searched entry must hold a color before the first query
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      if ($urandom_range(7) == 0) idle_cycles($urandom_range(1, 8));
      load_entry(i, random_color());
    end

    // skipped top entry: an exact white match there must never win
    load_entry(PALETTE_ENTRIES - 1, {PAL_W{1'b1}});
    query_point(GRID_LEVELS - 1, GRID_LEVELS - 1, GRID_LEVELS - 1);
    // tie on white: lowest index wins
    load_entry(200, {PAL_W{1'b1}});
    load_entry(100, {PAL_W{1'b1}});
    query_point(GRID_LEVELS - 1, GRID_LEVELS - 1, GRID_LEVELS - 1);
    // tie on black, then entry zero joins the tie
    load_entry(41, '0);
    load_entry(40, '0);
    query_point(0, 0, 0);
    load_entry(0, '0);
    query_point(0, 0, 0);
    // exact on-grid match in the last searched entry
    load_entry(PALETTE_ENTRIES - 2, {8'd131, 8'd8, 8'd246});
    query_point(30, 1, 16);
    query_point(GRID_LEVELS - 1, 0, 0);
    query_point(0, GRID_LEVELS - 1, 0);
    query_point(0, 0, GRID_LEVELS - 1);
    query_point(15, 16, 17);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      quiet = (i >= RANDOM_WORDS - CALM_WORDS);
      if (!quiet && $urandom_range(3) == 0) idle_cycles($urandom_range(1, 8));
      if ($urandom_range(99) < 35)
        query_point(random_level(), random_level(), random_level());
      else
        load_entry($urandom_range(PALETTE_ENTRIES - 1), random_color());
    end
    @(negedge clk);
    req.valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
